### src/eegp_pkg.sv
// Package: constants and shared types for the raw EEG sample parser.
`default_nettype none
package eegp_pkg;

  localparam logic [7:0] SYNC_BYTE   = 8'hAA;
  localparam logic [7:0] RAW_CODE    = 8'h80;
  localparam logic [7:0] RAW_LEN_MAX = 8'd2;

  typedef struct packed {
    logic               valid;
    logic signed [15:0] sample;
  } sample_t;

endpackage
`default_nettype wire

### src/eegp_in_stage.sv
// Input register stage: holds one received byte until the parser takes it.
`default_nettype none
module eegp_in_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] in_byte
  input  wire logic       take,
  output logic            in_valid,
  output logic [7:0]      in_byte
);
  import eegp_pkg::*;

  assign s_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

endmodule
`default_nettype wire

### src/eegp_parser.sv
// Packet parser: phase tracking and sample assembly, one byte per cycle while take is high.
`default_nettype none
module eegp_parser (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,
  input  wire logic [7:0] in_byte,
  output eegp_pkg::sample_t result
);
  import eegp_pkg::*;

  typedef enum logic [2:0] {
    PH_SYNC1  = 3'd0,
    PH_SYNC2  = 3'd1,
    PH_LEN    = 3'd2,
    PH_CODE   = 3'd3,
    PH_RAWLEN = 3'd4,
    PH_DATA   = 3'd5,
    PH_CHECK  = 3'd6
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] raw_remaining, raw_remaining_next;
  logic       high_byte_held, high_byte_held_next;
  logic [7:0] partial_sample, partial_sample_next;

  always_comb begin
    phase_next          = phase;
    raw_remaining_next  = raw_remaining;
    high_byte_held_next = high_byte_held;
    partial_sample_next = partial_sample;
    result.valid        = 1'b0;
    result.sample       = {partial_sample, in_byte};
    unique case (phase)
      PH_SYNC2: phase_next = (in_byte == SYNC_BYTE) ? PH_LEN : PH_SYNC1;
      PH_LEN: begin
        if (in_byte != SYNC_BYTE) begin
          phase_next = PH_CODE;
        end
      end
      PH_CODE: phase_next = (in_byte == RAW_CODE) ? PH_RAWLEN : PH_SYNC1;
      PH_RAWLEN: begin
        raw_remaining_next  = in_byte;
        high_byte_held_next = 1'b0;
        phase_next          = PH_DATA;
      end
      PH_DATA: begin
        if (raw_remaining > RAW_LEN_MAX || raw_remaining == 8'd0) begin
          phase_next = PH_SYNC1;
        end else begin
          if (!high_byte_held) begin
            partial_sample_next = in_byte;
            high_byte_held_next = 1'b1;
          end else begin
            result.valid        = 1'b1;
            high_byte_held_next = 1'b0;
          end
          raw_remaining_next = raw_remaining - 8'd1;
          if (raw_remaining == 8'd1) begin
            phase_next = PH_CHECK;
          end
        end
      end
      PH_CHECK: phase_next = PH_SYNC1;
      default: phase_next = (in_byte == SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SYNC1;
      raw_remaining  <= 8'd0;
      high_byte_held <= 1'b0;
      partial_sample <= 8'd0;
    end else if (take) begin
      phase          <= phase_next;
      raw_remaining  <= raw_remaining_next;
      high_byte_held <= high_byte_held_next;
      partial_sample <= partial_sample_next;
    end
  end

endmodule
`default_nettype wire

### src/eegp_out_stage.sv
// Result register: holds one finished sample until the receiver takes it.
`default_nettype none
module eegp_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire eegp_pkg::sample_t result,
  output logic                   can_load,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [15:0]            m_tdata   // [15:0] eeg_sample
);
  import eegp_pkg::*;

  assign can_load = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= result.valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (take && result.valid) begin
      m_tdata <= result.sample;
    end
  end

endmodule
`default_nettype wire

### src/eeg_packet_raw_sample_parser.sv
// Top level of the raw EEG sample parser.
// Usage:
//   s_* carries one received serial byte per item (s_tdata[7:0]).
//   m_* carries one signed 16-bit raw EEG sample per item (m_tdata[15:0]),
//   assembled high byte first from the data bytes of a raw-EEG packet.
//   Sync, length, code, raw length and checksum bytes produce no item.
// Path: a byte accepted into the input register is parsed combinationally
//   when taken; a sample it completes is then loaded into the result register.
// Throughput: one byte per cycle while the result register can load; the
//   phase is updated between the input register and the result register.
// Reset (rst, synchronous): both stages empty, parser back to hunting for
//   the first sync byte, no held high byte.
// Stall: while a sample waits on m_tready, the parser holds; the input
//   register takes at most one more byte, then s_tready stays low until
//   the result register is drained.
`default_nettype none
module eeg_packet_raw_sample_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // [15:0] eeg_sample
);
  import eegp_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       can_load;
  logic       take;
  sample_t    result;

  assign take = in_valid && can_load;

  eegp_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .take     (take),
    .in_valid (in_valid),
    .in_byte  (in_byte)
  );

  eegp_parser u_parse (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .in_byte (in_byte),
    .result  (result)
  );

  eegp_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .result   (result),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

`ifndef SYNTHESIS
  a_out_after_take: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(take))
    else $error("sample appeared without a parsed byte");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!m_tvalid && !in_valid))
    else $error("stages not empty after reset");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> in_valid)
    else $error("accepted byte lost");

  a_no_take_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !take)
    else $error("parser advanced while result stalled");
`endif

endmodule
`default_nettype wire
